@@ hdl/prq_pkg.sv @@
// Shared constants and action codes for the palindrome range query core.
package prq_pkg;

   localparam int MAX_LEN    = 2048;
   localparam int VALUE_BITS = 16;
   localparam int POS_BITS   = 12;
   localparam int ADDR_BITS  = $clog2(MAX_LEN);

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   localparam logic [POS_BITS-1:0] MAX_LEN_POS = POS_BITS'(MAX_LEN);

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [POS_BITS-1:0]   pos_type;

endpackage

@@ hdl/prq_store.sv @@
// Sequence store: one write port, two registered read ports.
module prq_store
   import prq_pkg::*;
(
   input  logic      clock,
   input  logic      wr_en,
   input  addr_type  wr_addr,
   input  value_type wr_data,
   input  logic      rd_en,
   input  addr_type  rd_addr_a,
   input  addr_type  rd_addr_b,
   output value_type rd_data_a,
   output value_type rd_data_b
);

   value_type mem [MAX_LEN];
   value_type rd_a_ff;
   value_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ hdl/palindrome_range_query_core.sv @@
// Top level of the palindrome range query core: command decode and span scan.
//
// Clear and append items are handled while idle; their result appears on
// the cycle after start is taken, and busy stays low so the next item may
// follow at once. A valid query scans the span from both ends, one pair per
// cycle through the two read ports of the sequence store, and answers once
// the two ends meet, earlier on the first mismatching pair; busy is high
// meanwhile. A bad range answers on the next cycle. Results are shown for a
// single cycle with rsp_valid high and cannot be held off. No clearing pass
// is needed after reset: only positions written since the last clear are
// ever read.
module palindrome_range_query_core
   import prq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [1:0]      req_action,
   input  logic [15:0]     req_value,
   input  logic [11:0]     req_start_req,
   input  logic [11:0]     req_end_req,
   output logic            rsp_valid,
   output logic            rsp_is_palindrome,
   output logic            rsp_error
);

   localparam logic S_IDLE  = 1'b0;
   localparam logic S_QUERY = 1'b1;

   logic      state_ff, state_in;
   pos_type   length_ff, length_in;
   pos_type   lo_ff, lo_in;
   pos_type   hi_ff, hi_in;
   logic      pend_ff, pend_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_pal_ff, rsp_pal_in;
   logic      rsp_err_ff, rsp_err_in;

   logic      accept;
   logic      wr_en;
   logic      rd_en;
   value_type rd_data_a;
   value_type rd_data_b;
   logic      mismatch;
   logic      bad_range;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign bad_range = (req_start_req == '0) || (req_start_req > req_end_req) ||
                      (req_end_req > length_ff);

   // a pair read last cycle is compared now
   assign mismatch = pend_ff && (rd_data_a != rd_data_b);

   always_comb begin
      state_in     = state_ff;
      length_in    = length_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      pend_in      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_pal_in   = 1'b0;
      rsp_err_in   = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_CLEAR: begin
                     length_in    = '0;
                     rsp_valid_in = 1'b1;
                  end
                  ACT_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (length_ff == MAX_LEN_POS) begin
                        rsp_err_in = 1'b1;
                     end else begin
                        wr_en     = 1'b1;
                        length_in = length_ff + 1'b1;
                     end
                  end
                  ACT_QUERY: begin
                     if (bad_range) begin
                        rsp_valid_in = 1'b1;
                        rsp_err_in   = 1'b1;
                     end else begin
                        lo_in    = req_start_req;
                        hi_in    = req_end_req;
                        state_in = S_QUERY;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_QUERY: begin
            if (mismatch) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (lo_ff < hi_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               lo_in   = lo_ff + 1'b1;
               hi_in   = hi_ff - 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_pal_in   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         length_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      rsp_pal_ff <= rsp_pal_in;
      rsp_err_ff <= rsp_err_in;
   end

   // writes happen only while idle and reads only while scanning, so the
   // busy interlock keeps the two apart
   prq_store u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (length_ff[ADDR_BITS-1:0]),
      .wr_data   (req_value[VALUE_BITS-1:0]),
      .rd_en     (rd_en),
      .rd_addr_a (addr_type'(lo_ff - 1'b1)),
      .rd_addr_b (addr_type'(hi_ff - 1'b1)),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_palindrome = rsp_pal_ff;
   assign rsp_error         = rsp_err_ff;

endmodule
